// ===== hw/rtl/mma_pkg.sv =====
// Shared types and constants for the matrix multiply-add block.
package mma_pkg;

	// Default largest matrix dimension supported by the element stores.
	localparam int MAX_DIM_DEF = 8;

	// Fixed field widths.
	localparam int VAL_W = 16;
	localparam int D_W   = 35;
	localparam int IDX_OUT_W = 3;
	localparam int CFG_W = 4;

	// Dimension register value after reset.
	localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} mma_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic job_start;
		logic issue;
		logic first_k;
		logic last_k;
		logic last_c;
		logic last_elem;
	} mma_cmd_t;

	// Tag that travels with each product through the pipeline.
	typedef struct packed {
		logic                 first_k;
		logic                 last_k;
		logic                 last_elem;
		logic [IDX_OUT_W-1:0] row;
		logic [IDX_OUT_W-1:0] col;
	} mma_tag_t;

endpackage

// ===== hw/rtl/matrix_multiply_add.sv =====
// Top level of the matrix multiply-add block: D = A * B + C.
//
// Channel   Direction  Handshake                    Beat
// input     in         start, taken when !busy      a_value, b_value, c_value
// config    in         cfg_valid / cfg_ready        cfg_data (matrix dimension)
// result    out        result_valid strobe, 1 cycle d_value, row, col, last_of_matrix
//
// Loads take one cycle per item while busy is low. The item that completes a job of
// dimension n starts the compute, which holds busy high through the last term: one
// shared multiplier and accumulator step through each dot product, one term per cycle.
// Each result passes the read, product and result registers after its last term.
// Reset clears the load count and sets the dimension to 8; the stores are not cleared.
// The receiver cannot stall, so every result beat is shown for exactly one cycle.
module matrix_multiply_add #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [mma_pkg::VAL_W-1:0]   a_value,
	input  logic signed [mma_pkg::VAL_W-1:0]   b_value,
	input  logic signed [mma_pkg::VAL_W-1:0]   c_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mma_pkg::CFG_W-1:0]          cfg_data,
	output logic                               result_valid,
	output logic signed [mma_pkg::D_W-1:0]     d_value,
	output logic [mma_pkg::IDX_OUT_W-1:0]      row,
	output logic [mma_pkg::IDX_OUT_W-1:0]      col,
	output logic                               last_of_matrix
);
	import mma_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int N_W    = $clog2(MAX_DIM + 1);

	mma_cmd_t          cmd;
	logic [ADDR_W-1:0] wr_addr;
	logic [N_W-1:0]    n_use;
	logic [IDX_W-1:0]  row_idx, col_idx;

	// Sequencer and state machine.
	mma_ctrl #(
		.MAX_DIM(MAX_DIM)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.n_use    (n_use),
		.row_idx  (row_idx),
		.col_idx  (col_idx)
	);

	// Stores, multiplier and accumulator.
	mma_dp #(
		.MAX_DIM(MAX_DIM)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.wr_addr       (wr_addr),
		.n_use         (n_use),
		.row_idx       (row_idx),
		.col_idx       (col_idx),
		.a_value       (a_value),
		.b_value       (b_value),
		.c_value       (c_value),
		.result_valid  (result_valid),
		.d_value       (d_value),
		.row           (row),
		.col           (col),
		.last_of_matrix(last_of_matrix)
	);

endmodule

// ===== hw/rtl/mma_ctrl.sv =====
// Controller: dimension register, load count, loop sequencer and state machine.
module mma_ctrl #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [mma_pkg::CFG_W-1:0]   cfg_data,
	output mma_pkg::mma_cmd_t           cmd,
	output logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
	output logic [$clog2(MAX_DIM+1)-1:0] n_use,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] row_idx,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col_idx
);
	import mma_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int N_W    = $clog2(MAX_DIM + 1);
	localparam int TOT_W  = $clog2(DEPTH + 1);

	mma_state_t        state_q, state_d;
	logic [CFG_W-1:0]  dim_q;
	logic [ADDR_W-1:0] count_q;
	logic [IDX_W-1:0]  k_q, c_q, r_q;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-1:0]  count_inc;
	logic [IDX_W-1:0]  n_last;
	logic              complete;
	logic              last_k, last_c, last_r;

	// Dimension in force, clamped to the supported range.
	always_comb begin
		if (dim_q == '0) begin
			n_use = N_W'(1);
		end else if (int'(dim_q) > MAX_DIM) begin
			n_use = N_W'(MAX_DIM);
		end else begin
			n_use = N_W'(dim_q);
		end
	end

	assign total     = TOT_W'(n_use) * TOT_W'(n_use);
	assign count_inc = TOT_W'(count_q) + TOT_W'(1);
	assign complete  = (count_inc >= total);
	assign n_last    = IDX_W'(n_use - N_W'(1));

	assign last_k = (k_q == n_last);
	assign last_c = (c_q == n_last);
	assign last_r = (r_q == n_last);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start && complete) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_k && last_c && last_r) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Output decode.
	always_comb begin
		cmd       = '0;
		busy      = 1'b0;
		cfg_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cfg_ready     = 1'b1;
				cmd.load      = start;
				cmd.job_start = start && complete;
			end
			ST_RUN: begin
				busy          = 1'b1;
				cmd.issue     = 1'b1;
				cmd.first_k   = (k_q == '0);
				cmd.last_k    = last_k;
				cmd.last_c    = last_c;
				cmd.last_elem = last_k && last_c && last_r;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	assign wr_addr = count_q;
	assign row_idx = r_q;
	assign col_idx = c_q;

	// State, configuration register, load count and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dim_q   <= DIM_RESET;
			count_q <= '0;
			k_q     <= '0;
			c_q     <= '0;
			r_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				dim_q <= cfg_data;
			end
			if (cmd.load) begin
				count_q <= complete ? '0 : ADDR_W'(count_inc);
			end
			if (cmd.job_start) begin
				k_q <= '0;
				c_q <= '0;
				r_q <= '0;
			end else if (cmd.issue) begin
				if (!last_k) begin
					k_q <= k_q + IDX_W'(1);
				end else begin
					k_q <= '0;
					if (!last_c) begin
						c_q <= c_q + IDX_W'(1);
					end else begin
						c_q <= '0;
						r_q <= r_q + IDX_W'(1);
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/mma_dp.sv =====
// Datapath: element stores, address pointers, multiplier and accumulator.
module mma_dp #(
	parameter int MAX_DIM = mma_pkg::MAX_DIM_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mma_pkg::mma_cmd_t                       cmd,
	input  logic [((MAX_DIM*MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] wr_addr,
	input  logic [$clog2(MAX_DIM+1)-1:0]            n_use,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] row_idx,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] col_idx,
	input  logic signed [mma_pkg::VAL_W-1:0]        a_value,
	input  logic signed [mma_pkg::VAL_W-1:0]        b_value,
	input  logic signed [mma_pkg::VAL_W-1:0]        c_value,
	output logic                                    result_valid,
	output logic signed [mma_pkg::D_W-1:0]          d_value,
	output logic [mma_pkg::IDX_OUT_W-1:0]           row,
	output logic [mma_pkg::IDX_OUT_W-1:0]           col,
	output logic                                    last_of_matrix
);
	import mma_pkg::*;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W  = D_W + 1 + $clog2(MAX_DIM);
	localparam int PROD_W = 2 * VAL_W;

	logic [VAL_W-1:0] a_mem [DEPTH];
	logic [VAL_W-1:0] b_mem [DEPTH];
	logic [VAL_W-1:0] c_mem [DEPTH];

	logic [ADDR_W-1:0] a_ptr_q, b_ptr_q, c_ptr_q, row_base_q;
	logic [ADDR_W-1:0] n_step;

	logic signed [VAL_W-1:0]  a_rd_s1, b_rd_s1, c_rd_s1;
	logic signed [VAL_W-1:0]  c_s2;
	logic signed [PROD_W-1:0] prod_s2;
	mma_tag_t                 tag_s1, tag_s2;
	logic                     valid_s1, valid_s2;

	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  c_ext, base, sum;
	logic [ACC_W-D_W:0]       sum_hi;
	logic signed [D_W-1:0]    d_sat;

	logic                     result_valid_q;
	logic signed [D_W-1:0]    d_value_q;
	logic [IDX_OUT_W-1:0]     row_q, col_q;
	logic                     last_q;

	assign n_step = ADDR_W'(n_use);

	// Address pointers walk row r of A, column c of B and element (r, c) of C.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_ptr_q    <= '0;
			b_ptr_q    <= '0;
			c_ptr_q    <= '0;
			row_base_q <= '0;
		end else if (cmd.job_start) begin
			a_ptr_q    <= '0;
			b_ptr_q    <= '0;
			c_ptr_q    <= '0;
			row_base_q <= '0;
		end else if (cmd.issue) begin
			if (!cmd.last_k) begin
				a_ptr_q <= a_ptr_q + ADDR_W'(1);
				b_ptr_q <= b_ptr_q + n_step;
			end else begin
				c_ptr_q <= c_ptr_q + ADDR_W'(1);
				if (!cmd.last_c) begin
					a_ptr_q <= row_base_q;
					b_ptr_q <= ADDR_W'(col_idx) + ADDR_W'(1);
				end else begin
					a_ptr_q    <= row_base_q + n_step;
					b_ptr_q    <= '0;
					row_base_q <= row_base_q + n_step;
				end
			end
		end
	end

	// Element stores: one write port for loads, one registered read port each.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_mem[wr_addr] <= a_value;
			b_mem[wr_addr] <= b_value;
			c_mem[wr_addr] <= c_value;
		end
		if (cmd.issue) begin
			a_rd_s1 <= a_mem[a_ptr_q];
			b_rd_s1 <= b_mem[b_ptr_q];
			c_rd_s1 <= c_mem[c_ptr_q];
		end
	end

	// Tags follow the reads; the multiply stage registers the product.
	always_ff @(posedge clk) begin
		tag_s1.first_k   <= cmd.first_k;
		tag_s1.last_k    <= cmd.last_k;
		tag_s1.last_elem <= cmd.last_elem;
		tag_s1.row       <= IDX_OUT_W'(row_idx);
		tag_s1.col       <= IDX_OUT_W'(col_idx);
		tag_s2           <= tag_s1;
		prod_s2          <= PROD_W'(a_rd_s1) * PROD_W'(b_rd_s1);
		c_s2             <= c_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
		end
	end

	// Accumulate; the first product of an element starts from C at Q16.16.
	assign c_ext  = ACC_W'(c_s2);
	assign base   = tag_s2.first_k ? (c_ext <<< 8) : acc_q;
	assign sum    = base + ACC_W'(prod_s2);
	assign sum_hi = sum[ACC_W-1:D_W-1];

	// Saturate to the signed result range.
	always_comb begin
		if ((&sum_hi) || !(|sum_hi)) begin
			d_sat = sum[D_W-1:0];
		end else if (sum[ACC_W-1]) begin
			d_sat = {1'b1, {(D_W-1){1'b0}}};
		end else begin
			d_sat = {1'b0, {(D_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			acc_q <= sum;
		end
		if (valid_s2 && tag_s2.last_k) begin
			d_value_q <= d_sat;
			row_q     <= tag_s2.row;
			col_q     <= tag_s2.col;
			last_q    <= tag_s2.last_elem;
		end
	end

	// Result strobe, high for one cycle per element of D.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= valid_s2 && tag_s2.last_k;
		end
	end

	assign result_valid   = result_valid_q;
	assign d_value        = d_value_q;
	assign row            = row_q;
	assign col            = col_q;
	assign last_of_matrix = last_q;

endmodule

// ===== hw/rtl/mma_checker.sv =====
// Port-level checks for the matrix multiply-add block, bound to its top level.
module mma_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              result_valid,
	input logic [mma_pkg::IDX_OUT_W-1:0]     row,
	input logic [mma_pkg::IDX_OUT_W-1:0]     col,
	input logic                              last_of_matrix
);

	// Result beats are single-cycle strobes that are never back to back.
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result beat shown on two consecutive cycles");

	// The final element of a square matrix lies on the diagonal.
	a_last_on_diagonal: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_matrix |-> row == col)
		else $error("final element is not on the diagonal");

	// A compute run only begins after an accepted input beat.
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without an accepted input beat");

	// The final result leaves the pipeline after the run ends, through the s2 stage and the result register.
	a_last_follows_run: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> ##2 (result_valid && last_of_matrix))
		else $error("final result did not follow the end of the run");

endmodule

bind matrix_multiply_add mma_checker u_mma_checker (.*);
